// File: src/csd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types, fixed-point constants and helpers of the concentric
// square-to-disk mapper.
// ----------------------------------------------------------------------------
package csd_pkg;

  // Inner fixed-point format: Q.30 for ratio, angle and unit components
  localparam int IW     = 30;
  localparam int QW     = IW + 1;       // value in [0, 1.0]
  localparam int PW     = IW + QW;      // Q.30 times [0, 1.0]
  localparam int SQW    = 2 * IW;
  localparam int IN_FW  = 16;           // width of each input coordinate

  // Constant division by reciprocal: floor(a/d) = (a * ceil(2^37/d)) >> 37
  // holds for every a below 2^30 and every d up to 128.
  localparam int RCP_S  = 37;
  localparam int RCPW   = 35;
  localparam int MW     = IW + RCPW;
  localparam int NSTEP  = 3;            // shared Horner steps of sin and cos

  localparam logic [QW-1:0]   T_ONE   = {1'b1, {IW{1'b0}}};
  localparam logic [IW-1:0]   HALF    = {1'b1, {(IW-1){1'b0}}};
  localparam logic [IW-1:0]   PI4     = 30'd843314857;
  localparam logic [63:0]     RCP_NUM = 64'd1 << RCP_S;

  localparam logic [RCPW-1:0] RCP_6  = RCPW'((RCP_NUM + 64'd5)  / 64'd6);
  localparam logic [RCPW-1:0] RCP_12 = RCPW'((RCP_NUM + 64'd11) / 64'd12);
  localparam logic [RCPW-1:0] RCP_20 = RCPW'((RCP_NUM + 64'd19) / 64'd20);
  localparam logic [RCPW-1:0] RCP_30 = RCPW'((RCP_NUM + 64'd29) / 64'd30);
  localparam logic [RCPW-1:0] RCP_42 = RCPW'((RCP_NUM + 64'd41) / 64'd42);
  localparam logic [RCPW-1:0] RCP_56 = RCPW'((RCP_NUM + 64'd55) / 64'd56);
  localparam logic [RCPW-1:0] RCP_72 = RCPW'((RCP_NUM + 64'd71) / 64'd72);
  localparam logic [RCPW-1:0] RCP_90 = RCPW'((RCP_NUM + 64'd89) / 64'd90);

  localparam logic [RCPW-1:0] RCP_SIN [NSTEP] = '{RCP_42, RCP_20, RCP_6};
  localparam logic [RCPW-1:0] RCP_COS [NSTEP] = '{RCP_56, RCP_30, RCP_12};

  typedef enum logic [1:0] {
    SEC_RIGHT,
    SEC_TOP,
    SEC_LEFT,
    SEC_BOTTOM
  } sector_t;

  typedef struct packed {
    sector_t sector;
    logic    rneg;    // radius negative (bottom sector tie case)
    logic    qneg;    // sine takes the sign of the ratio
    logic    zero;    // origin, forced to (0,0)
  } ctl_t;

  typedef struct packed {
    logic [IW-1:0] a2;
    logic [IW-1:0] psi;
    logic [MW-1:0] ms;   // sin term times reciprocal, not yet shifted
    logic [MW-1:0] mc;   // cos term times reciprocal, not yet shifted
  } hrn_t;

  // 1 - floor(m / 2^RCP_S)
  function automatic logic [QW-1:0] hrn_term(input logic [MW-1:0] m);
    return T_ONE - QW'(m[MW-1:RCP_S]);
  endfunction

endpackage
`default_nettype wire

// File: src/csd_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csd_div_cell
// One restoring division cell: decides one quotient bit of the ratio,
// passes the partial remainder and the side data to the next cell.
// ----------------------------------------------------------------------------
module csd_div_cell #(
  parameter int MAGW = 17
) (
  input  wire  logic                    clk,
  input  wire  logic                    rst_n,
  input  wire  logic                    en,
  input  wire  logic                    in_vld,
  input  wire  csd_pkg::ctl_t           in_ctl,
  input  wire  logic [MAGW-1:0]         in_rmag,
  input  wire  logic [MAGW-1:0]         in_den,
  input  wire  logic [MAGW:0]           in_rem,
  input  wire  logic [csd_pkg::QW-1:0]  in_q,
  output logic                          out_vld,
  output csd_pkg::ctl_t                 out_ctl,
  output logic [MAGW-1:0]               out_rmag,
  output logic [MAGW-1:0]               out_den,
  output logic [MAGW:0]                 out_rem,
  output logic [csd_pkg::QW-1:0]        out_q
);

  logic                         vld_r;
  csd_pkg::ctl_t                ctl_r;
  logic [MAGW-1:0]              rmag_r;
  logic [MAGW-1:0]              den_r;
  logic [MAGW:0]                rem_r, rem_nxt;
  logic [csd_pkg::QW-1:0]       q_r, q_nxt;
  logic [MAGW:0]                den_x, diff;
  logic [MAGW-1:0]              rest;
  logic                         ge;

  assign den_x   = {1'b0, in_den};
  assign ge      = in_rem >= den_x;
  assign diff    = in_rem - den_x;
  // remainder stays below den, so it fits MAGW bits before the shift
  assign rest    = ge ? diff[MAGW-1:0] : in_rem[MAGW-1:0];
  assign rem_nxt = {rest, 1'b0};
  assign q_nxt   = {in_q[csd_pkg::QW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r  <= in_ctl;
      rmag_r <= in_rmag;
      den_r  <= in_den;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_ctl  = ctl_r;
  assign out_rmag = rmag_r;
  assign out_den  = den_r;
  assign out_rem  = rem_r;
  assign out_q    = q_r;

endmodule
`default_nettype wire

// File: src/csd_horner_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csd_horner_cell
// One Horner step of the sine and cosine series, two register stages:
// t = 1 - m>>37 and a2*t, then (a2*t >> 30) times the next reciprocal.
// ----------------------------------------------------------------------------
module csd_horner_cell #(
  parameter int MAGW = 17
) (
  input  wire  logic                      clk,
  input  wire  logic                      rst_n,
  input  wire  logic                      en,
  input  wire  logic [csd_pkg::RCPW-1:0]  rcp_s,
  input  wire  logic [csd_pkg::RCPW-1:0]  rcp_c,
  input  wire  logic                      in_vld,
  input  wire  csd_pkg::ctl_t             in_ctl,
  input  wire  logic [MAGW-1:0]           in_rmag,
  input  wire  csd_pkg::hrn_t             in_h,
  output logic                            out_vld,
  output csd_pkg::ctl_t                   out_ctl,
  output logic [MAGW-1:0]                 out_rmag,
  output csd_pkg::hrn_t                   out_h
);

  localparam int IW = csd_pkg::IW;
  localparam int PW = csd_pkg::PW;
  localparam int MW = csd_pkg::MW;

  // product stage
  logic              v1_r;
  csd_pkg::ctl_t     ctl1_r;
  logic [MAGW-1:0]   rmag1_r;
  logic [IW-1:0]     a2_1_r, psi1_r;
  logic [PW-1:0]     ps_r, pc_r, ps_nxt, pc_nxt;
  // reciprocal stage
  logic              v2_r;
  csd_pkg::ctl_t     ctl2_r;
  logic [MAGW-1:0]   rmag2_r;
  csd_pkg::hrn_t     h2_r, h2_nxt;

  assign ps_nxt = PW'(in_h.a2) * PW'(csd_pkg::hrn_term(in_h.ms));
  assign pc_nxt = PW'(in_h.a2) * PW'(csd_pkg::hrn_term(in_h.mc));

  always_comb begin
    h2_nxt.a2  = a2_1_r;
    h2_nxt.psi = psi1_r;
    h2_nxt.ms  = MW'(ps_r[2*IW-1:IW]) * MW'(rcp_s);
    h2_nxt.mc  = MW'(pc_r[2*IW-1:IW]) * MW'(rcp_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r  <= in_ctl;
      rmag1_r <= in_rmag;
      a2_1_r  <= in_h.a2;
      psi1_r  <= in_h.psi;
      ps_r    <= ps_nxt;
      pc_r    <= pc_nxt;
      ctl2_r  <= ctl1_r;
      rmag2_r <= rmag1_r;
      h2_r    <= h2_nxt;
    end
  end

  assign out_vld  = v2_r;
  assign out_ctl  = ctl2_r;
  assign out_rmag = rmag2_r;
  assign out_h    = h2_r;

endmodule
`default_nettype wire

// File: src/concentric_square_to_disk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// concentric_square_to_disk
// Concentric mapping of a unit-square sample onto the unit disk.
// ----------------------------------------------------------------------------
// Input stream (in_*): one sample per transfer, square_x and square_y in
// unsigned Q0.FRAC_BITS; input bits at and above FRAC_BITS are ignored.
// Output stream (out_*): one result per sample, in order, disk_x and
// disk_y in signed Q1.FRAC_BITS two's complement.
// The pipeline has 45 register stages; one sample is taken every cycle
// while in_tready is high. The stages are the front register, the 31-cell
// restoring divider for the coordinate ratio (one quotient bit per cell),
// the angle multiply, three Horner cells for sin/cos, the sin/cos finish,
// the radius scaling and the output register.
// The origin sample yields (0,0).
// Reset clears all valid flags; no result is presented afterwards until
// a new sample arrives. When the receiver stalls, the result holds in the
// output register and the pipeline keeps taking samples until its last
// stage is also occupied; then in_tready drops until out_tready returns.
// ----------------------------------------------------------------------------
module concentric_square_to_disk #(
  parameter int FRAC_BITS = 16
) (
  input  wire  logic                                       clk,
  input  wire  logic                                       rst_n,
  input  wire  logic                                       in_tvalid,
  output logic                                             in_tready,
  // [15:0] square_x, [31:16] square_y
  input  wire  logic [2*csd_pkg::IN_FW-1:0]                in_tdata,
  output logic                                             out_tvalid,
  input  wire  logic                                       out_tready,
  // [FRAC_BITS+1:0] disk_x, next FRAC_BITS+2 bits disk_y, zero fill to bytes
  output logic [((2*(FRAC_BITS+2)+7)/8)*8-1:0]             out_tdata
);

  localparam int OW    = FRAC_BITS + 2;
  localparam int SW    = FRAC_BITS + 2;
  localparam int MAGW  = FRAC_BITS + 1;
  localparam int OTW   = ((2*OW+7)/8)*8;
  localparam int XB    = (FRAC_BITS < csd_pkg::IN_FW) ? FRAC_BITS : csd_pkg::IN_FW;
  localparam int IW    = csd_pkg::IW;
  localparam int QW    = csd_pkg::QW;
  localparam int PW    = csd_pkg::PW;
  localparam int SQW   = csd_pkg::SQW;
  localparam int MW    = csd_pkg::MW;
  localparam int NSTEP = csd_pkg::NSTEP;
  localparam int SPW   = MAGW + QW;
  localparam logic [SW-1:0] ONE_S = {2'b01, {FRAC_BITS{1'b0}}};

  logic pipe_en, out_ld;

  // ---------------------------------------------------------------- front
  logic [XB-1:0]          x, y;
  logic signed [SW-1:0]   sx, sy, nsx, nsy;
  logic [MAGW-1:0]        ax, ay;
  csd_pkg::ctl_t          f_ctl;
  logic [MAGW-1:0]        f_rmag, f_num, f_den;

  logic                   fr_vld_r;
  csd_pkg::ctl_t          fr_ctl_r;
  logic [MAGW-1:0]        fr_rmag_r, fr_num_r, fr_den_r;

  assign x   = in_tdata[XB-1:0];
  assign y   = in_tdata[csd_pkg::IN_FW +: XB];
  assign sx  = $signed(SW'({x, 1'b0}) - ONE_S);
  assign sy  = $signed(SW'({y, 1'b0}) - ONE_S);
  assign nsx = -sx;
  assign nsy = -sy;
  assign ax  = sx[SW-1] ? nsx[MAGW-1:0] : sx[MAGW-1:0];
  assign ay  = sy[SW-1] ? nsy[MAGW-1:0] : sy[MAGW-1:0];

  always_comb begin
    f_ctl.zero = (sx == '0) && (sy == '0);
    f_ctl.rneg = 1'b0;
    priority if (sx > sy && sx > nsy) begin
      f_ctl.sector = csd_pkg::SEC_RIGHT;
      f_ctl.qneg   = sy[SW-1];
      f_rmag       = ax;
      f_num        = ay;
      f_den        = ax;
    end else if (sx < sy && sx > nsy) begin
      f_ctl.sector = csd_pkg::SEC_TOP;
      f_ctl.qneg   = !sx[SW-1] && (sx != '0);
      f_rmag       = ay;
      f_num        = ax;
      f_den        = ay;
    end else if (sx < sy && sx < nsy) begin
      f_ctl.sector = csd_pkg::SEC_LEFT;
      f_ctl.qneg   = sy[SW-1];
      f_rmag       = ax;
      f_num        = ay;
      f_den        = ax;
    end else begin
      // ties land here; the radius is -sy and may be negative
      f_ctl.sector = csd_pkg::SEC_BOTTOM;
      f_ctl.rneg   = !sy[SW-1] && (sy != '0);
      f_ctl.qneg   = (sx[SW-1] == sy[SW-1]) && (sx != '0);
      f_rmag       = ay;
      f_num        = ax;
      f_den        = ay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else if (pipe_en) begin
      fr_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fr_ctl_r  <= f_ctl;
      fr_rmag_r <= f_rmag;
      fr_num_r  <= f_num;
      fr_den_r  <= f_den;
    end
  end

  // ------------------------------------------------------- divider chain
  logic                   div_vld  [QW+1];
  csd_pkg::ctl_t          div_ctl  [QW+1];
  logic [MAGW-1:0]        div_rmag [QW+1];
  logic [MAGW-1:0]        div_den  [QW+1];
  logic [MAGW:0]          div_rem  [QW+1];
  logic [QW-1:0]          div_q    [QW+1];

  assign div_vld[0]  = fr_vld_r;
  assign div_ctl[0]  = fr_ctl_r;
  assign div_rmag[0] = fr_rmag_r;
  assign div_den[0]  = fr_den_r;
  assign div_rem[0]  = {1'b0, fr_num_r};
  assign div_q[0]    = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    csd_div_cell #(.MAGW(MAGW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .in_vld   (div_vld[i]),
      .in_ctl   (div_ctl[i]),
      .in_rmag  (div_rmag[i]),
      .in_den   (div_den[i]),
      .in_rem   (div_rem[i]),
      .in_q     (div_q[i]),
      .out_vld  (div_vld[i+1]),
      .out_ctl  (div_ctl[i+1]),
      .out_rmag (div_rmag[i+1]),
      .out_den  (div_den[i+1]),
      .out_rem  (div_rem[i+1]),
      .out_q    (div_q[i+1])
    );
  end

  // ------------------------------------------------ angle and its square
  logic                   t0_vld_r, t1_vld_r, t2_vld_r;
  csd_pkg::ctl_t          t0_ctl_r, t1_ctl_r, t2_ctl_r;
  logic [MAGW-1:0]        t0_rmag_r, t1_rmag_r, t2_rmag_r;
  logic [PW-1:0]          t0_pp_r, psum;
  logic [IW-1:0]          psi, a2, t1_psi_r;
  logic [SQW-1:0]         t1_sq_r;
  csd_pkg::hrn_t          t2_h_r, t2_h_nxt;

  assign psum = t0_pp_r + PW'(csd_pkg::HALF);
  assign psi  = psum[SQW-1:IW];
  assign a2   = t1_sq_r[SQW-1:IW];

  always_comb begin
    t2_h_nxt.a2  = a2;
    t2_h_nxt.psi = t1_psi_r;
    t2_h_nxt.ms  = MW'(a2) * MW'(csd_pkg::RCP_72);
    t2_h_nxt.mc  = MW'(a2) * MW'(csd_pkg::RCP_90);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_vld_r <= 1'b0;
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
    end else if (pipe_en) begin
      t0_vld_r <= div_vld[QW];
      t1_vld_r <= t0_vld_r;
      t2_vld_r <= t1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      t0_ctl_r  <= div_ctl[QW];
      t0_rmag_r <= div_rmag[QW];
      t0_pp_r   <= PW'(div_q[QW]) * PW'(csd_pkg::PI4);
      t1_ctl_r  <= t0_ctl_r;
      t1_rmag_r <= t0_rmag_r;
      t1_psi_r  <= psi;
      t1_sq_r   <= SQW'(psi) * SQW'(psi);
      t2_ctl_r  <= t1_ctl_r;
      t2_rmag_r <= t1_rmag_r;
      t2_h_r    <= t2_h_nxt;
    end
  end

  // -------------------------------------------------------- Horner chain
  logic                   hrn_vld  [NSTEP+1];
  csd_pkg::ctl_t          hrn_ctl  [NSTEP+1];
  logic [MAGW-1:0]        hrn_rmag [NSTEP+1];
  csd_pkg::hrn_t          hrn_h    [NSTEP+1];

  assign hrn_vld[0]  = t2_vld_r;
  assign hrn_ctl[0]  = t2_ctl_r;
  assign hrn_rmag[0] = t2_rmag_r;
  assign hrn_h[0]    = t2_h_r;

  for (genvar i = 0; i < NSTEP; i++) begin : g_hrn
    csd_horner_cell #(.MAGW(MAGW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .rcp_s    (csd_pkg::RCP_SIN[i]),
      .rcp_c    (csd_pkg::RCP_COS[i]),
      .in_vld   (hrn_vld[i]),
      .in_ctl   (hrn_ctl[i]),
      .in_rmag  (hrn_rmag[i]),
      .in_h     (hrn_h[i]),
      .out_vld  (hrn_vld[i+1]),
      .out_ctl  (hrn_ctl[i+1]),
      .out_rmag (hrn_rmag[i+1]),
      .out_h    (hrn_h[i+1])
    );
  end

  // --------------------------------------------------- sin / cos finish
  logic                   ta_vld_r, tb_vld_r;
  csd_pkg::ctl_t          ta_ctl_r, tb_ctl_r;
  logic [MAGW-1:0]        ta_rmag_r, tb_rmag_r;
  logic [PW-1:0]          ta_ps_r, ta_pc_r;
  logic [QW-1:0]          tb_s_r, tb_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ta_vld_r <= 1'b0;
      tb_vld_r <= 1'b0;
    end else if (pipe_en) begin
      ta_vld_r <= hrn_vld[NSTEP];
      tb_vld_r <= ta_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ta_ctl_r  <= hrn_ctl[NSTEP];
      ta_rmag_r <= hrn_rmag[NSTEP];
      // sin = psi * t, cos = 1 - (a2 * t) / 2
      ta_ps_r   <= PW'(hrn_h[NSTEP].psi) * PW'(csd_pkg::hrn_term(hrn_h[NSTEP].ms));
      ta_pc_r   <= PW'(hrn_h[NSTEP].a2) * PW'(csd_pkg::hrn_term(hrn_h[NSTEP].mc));
      tb_ctl_r  <= ta_ctl_r;
      tb_rmag_r <= ta_rmag_r;
      tb_s_r    <= QW'(ta_ps_r[SQW-1:IW]);
      tb_c_r    <= csd_pkg::T_ONE - QW'(ta_pc_r[PW-1:IW+1]);
    end
  end

  // ------------------------------------------------ quarter turn, scale
  logic [QW-1:0]          umx, umy;
  logic                   ux_neg, uy_neg;
  logic                   sc_vld_r, sc_nx_r, sc_ny_r, sc_zero_r;
  logic [SPW-1:0]         sc_px_r, sc_py_r;

  always_comb begin
    unique case (tb_ctl_r.sector)
      csd_pkg::SEC_RIGHT: begin
        umx = tb_c_r;  ux_neg = 1'b0;
        umy = tb_s_r;  uy_neg = tb_ctl_r.qneg;
      end
      csd_pkg::SEC_TOP: begin
        umx = tb_s_r;  ux_neg = !tb_ctl_r.qneg;
        umy = tb_c_r;  uy_neg = 1'b0;
      end
      csd_pkg::SEC_LEFT: begin
        umx = tb_c_r;  ux_neg = 1'b1;
        umy = tb_s_r;  uy_neg = !tb_ctl_r.qneg;
      end
      csd_pkg::SEC_BOTTOM: begin
        umx = tb_s_r;  ux_neg = tb_ctl_r.qneg;
        umy = tb_c_r;  uy_neg = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else if (pipe_en) begin
      sc_vld_r <= tb_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sc_px_r   <= SPW'(tb_rmag_r) * SPW'(umx);
      sc_py_r   <= SPW'(tb_rmag_r) * SPW'(umy);
      sc_nx_r   <= tb_ctl_r.rneg ^ ux_neg;
      sc_ny_r   <= tb_ctl_r.rneg ^ uy_neg;
      sc_zero_r <= tb_ctl_r.zero;
    end
  end

  // ---------------------------------------------------- output register
  logic [SPW-1:0]         rx_sum, ry_sum;
  logic [OW-1:0]          rx, ry, dx_nxt, dy_nxt;
  logic                   out_vld_r;
  logic [OW-1:0]          out_dx_r, out_dy_r;

  assign rx_sum = sc_px_r + SPW'(csd_pkg::HALF);
  assign ry_sum = sc_py_r + SPW'(csd_pkg::HALF);
  assign rx     = rx_sum[SPW-1:IW];
  assign ry     = ry_sum[SPW-1:IW];
  assign dx_nxt = sc_zero_r ? '0 : (sc_nx_r ? -rx : rx);
  assign dy_nxt = sc_zero_r ? '0 : (sc_ny_r ? -ry : ry);

  // the pipe moves unless its last stage holds a result it cannot hand off
  assign out_ld  = !out_vld_r || out_tready;
  assign pipe_en = !sc_vld_r || out_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ld) begin
      out_vld_r <= sc_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_dx_r <= dx_nxt;
      out_dy_r <= dy_nxt;
    end
  end

  assign in_tready  = pipe_en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OTW'({out_dy_r, out_dx_r});

endmodule
`default_nettype wire

// File: src/csd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csd_checker
// Port-level checks of the concentric square-to-disk mapper.
// ----------------------------------------------------------------------------
module csd_checker #(
  parameter int FRAC_BITS = 16
) (
  input  wire  logic                                       clk,
  input  wire  logic                                       rst_n,
  input  wire  logic                                       in_tready,
  input  wire  logic                                       out_tvalid,
  input  wire  logic                                       out_tready,
  input  wire  logic [((2*(FRAC_BITS+2)+7)/8)*8-1:0]       out_tdata
);

  localparam int OW = FRAC_BITS + 2;
  localparam logic signed [OW-1:0] LIM_P = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [OW-1:0] LIM_N = -LIM_P;

  logic signed [OW-1:0] dx, dy;

  assign dx = $signed(out_tdata[OW-1:0]);
  assign dy = $signed(out_tdata[2*OW-1:OW]);

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result presented right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a free receiver never blocks the input side
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked while receiver is ready");

  // results lie in the closed unit square around the disk
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> dx <= LIM_P && dx >= LIM_N && dy <= LIM_P && dy >= LIM_N)
    else $error("result out of range");

endmodule

bind concentric_square_to_disk csd_checker #(.FRAC_BITS(FRAC_BITS)) u_csd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// File: dv/csd_checker.sv
// ----------------------------------------------------------------------------
// csd_scoreboard
// Watches both streams of the concentric square-to-disk mapper. For every
// input transfer it predicts the mapped disk point in fixed point and
// compares each output transfer, field by field, with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module csd_scoreboard #(
  parameter int FRAC_BITS = 16,
  parameter int OUT_W     = ((2*(FRAC_BITS+2)+7)/8)*8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [2*csd_pkg::IN_FW-1:0]  in_tdata,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [OUT_W-1:0]             out_tdata,
  output int                           fail_count,
  output int                           pending
);

  localparam int DW = FRAC_BITS + 2;
  localparam int QF = 30;                       // inner fraction bits
  localparam bit [63:0] Q_ONE  = 64'd1 << QF;
  localparam bit [63:0] Q_HALF = 64'd1 << (QF - 1);
  localparam bit [63:0] QUARTER_PI = 64'd843314857;

  typedef struct {
    logic [15:0]   sq_x;
    logic [15:0]   sq_y;
    logic [DW-1:0] disk_x;
    logic [DW-1:0] disk_y;
  } disk_point_t;

  disk_point_t expected_points[$];
  int          mismatches = 0;

  function automatic bit [63:0] magn(input longint v);
    bit [63:0] m;
    m = (v < 0) ? -v : v;
    return m;
  endfunction

  function automatic bit [63:0] qmul(input bit [63:0] a, input bit [63:0] b);
    return (a * b) >> QF;
  endfunction

  function automatic bit [63:0] horner(input bit [63:0] a2, input bit [63:0] t,
                                       input bit [63:0] d);
    return Q_ONE - qmul(a2, t) / d;
  endfunction

  // radius times unit component, magnitude rounded half up
  function automatic longint round_scale(input longint rad, input longint v);
    bit [63:0] p;
    longint    res;
    p   = (magn(rad) * magn(v) + Q_HALF) >> QF;
    res = p;
    return ((rad < 0) != (v < 0)) ? -res : res;
  endfunction

  function automatic disk_point_t map_to_disk(input logic [15:0] sq_x,
                                              input logic [15:0] sq_y);
    longint            cx, cy, rad, num, den, c, s, ux, uy, dx, dy;
    bit [63:0]         ratio, psi, a2, ts, tc;
    bit                sneg;
    csd_pkg::sector_t  sec;
    disk_point_t       pt;
    pt.sq_x   = sq_x;
    pt.sq_y   = sq_y;
    pt.disk_x = '0;
    pt.disk_y = '0;
    // bits at and above FRAC_BITS are ignored
    cx = sq_x;
    cy = sq_y;
    cx = cx & ((longint'(1) << FRAC_BITS) - 1);
    cy = cy & ((longint'(1) << FRAC_BITS) - 1);
    cx = 2 * cx - (longint'(1) << FRAC_BITS);
    cy = 2 * cy - (longint'(1) << FRAC_BITS);
    if (cx == 0 && cy == 0) return pt;   // origin maps to (0,0)

    if (cx > cy && cx > -cy) begin
      sec = csd_pkg::SEC_RIGHT;  rad = cx;  num = cy; den = cx; sneg = cy < 0;
    end else if (cx < cy && cx > -cy) begin
      sec = csd_pkg::SEC_TOP;    rad = cy;  num = cx; den = cy; sneg = cx > 0;
    end else if (cx < cy && cx < -cy) begin
      sec = csd_pkg::SEC_LEFT;   rad = -cx; num = cy; den = cx; sneg = cy < 0;
    end else begin
      // diagonal ties land here too; radius may come out negative
      sec = csd_pkg::SEC_BOTTOM; rad = -cy; num = cx; den = cy;
      sneg = ((cx < 0) == (cy < 0)) && cx != 0;
    end

    ratio = (magn(num) << QF) / magn(den);
    psi   = (ratio * QUARTER_PI + Q_HALF) >> QF;
    a2    = qmul(psi, psi);
    ts    = Q_ONE - a2 / 64'd72;
    tc    = Q_ONE - a2 / 64'd90;
    ts    = horner(a2, ts, 64'd42);
    ts    = horner(a2, ts, 64'd20);
    ts    = horner(a2, ts, 64'd6);
    tc    = horner(a2, tc, 64'd56);
    tc    = horner(a2, tc, 64'd30);
    tc    = horner(a2, tc, 64'd12);
    tc    = horner(a2, tc, 64'd2);
    ts    = qmul(psi, ts);
    c = tc;
    s = ts;
    if (sneg) s = -s;

    case (sec)
      csd_pkg::SEC_RIGHT: begin ux = c;  uy = s;  end
      csd_pkg::SEC_TOP:   begin ux = -s; uy = c;  end
      csd_pkg::SEC_LEFT:  begin ux = -c; uy = -s; end
      default:            begin ux = s;  uy = -c; end
    endcase

    dx = round_scale(rad, ux);
    dy = round_scale(rad, uy);
    pt.disk_x = dx[DW-1:0];
    pt.disk_y = dy[DW-1:0];
    return pt;
  endfunction

  always @(posedge clk) begin
    disk_point_t       want;
    logic [DW-1:0]     got_x, got_y;
    logic [OUT_W-1:0]  got_fill;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_x    = out_tdata[DW-1:0];
        got_y    = out_tdata[2*DW-1:DW];
        got_fill = out_tdata >> (2*DW);
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none got x=%0d y=%0d",
                   $time, $signed(got_x), $signed(got_y));
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (got_x !== want.disk_x) begin
            $display("%0t: disk_x for (%h,%h) expected %0d got %0d", $time,
                     want.sq_x, want.sq_y, $signed(want.disk_x), $signed(got_x));
            mismatches++;
          end
          if (got_y !== want.disk_y) begin
            $display("%0t: disk_y for (%h,%h) expected %0d got %0d", $time,
                     want.sq_x, want.sq_y, $signed(want.disk_y), $signed(got_y));
            mismatches++;
          end
          if (got_fill !== '0) begin
            $display("%0t: tdata fill for (%h,%h) expected 0 got %h", $time,
                     want.sq_x, want.sq_y, got_fill);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_points.push_back(map_to_disk(in_tdata[15:0], in_tdata[31:16]));
    end
    fail_count <= mismatches;
    pending    <= expected_points.size();
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the concentric square-to-disk mapper: directed corner,
// tie and origin samples, then mostly random samples with random gaps on
// the input and random stalls on the output. The scoreboard predicts and
// compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FB        = 16;
  localparam int OUT_W     = ((2*(FB+2)+7)/8)*8;
  localparam int N_RANDOM  = 430;
  localparam int IDLE_LIMIT = 2000;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [31:0]       in_tdata   = '0;
  logic              out_tready = 1'b0;
  logic              in_tready;
  logic              out_tvalid;
  logic [OUT_W-1:0]  out_tdata;
  int                fail_count;
  int                pending;
  int                quiet      = 0;
  bit                send_steady = 1'b0;
  bit                recv_steady = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  concentric_square_to_disk #(.FRAC_BITS(FB)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  csd_scoreboard #(.FRAC_BITS(FB), .OUT_W(OUT_W)) u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // steady stretches run with no idle cycles at all
  function automatic int draw_pause(input bit steady);
    return steady ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_sample(input logic [15:0] sq_x, input logic [15:0] sq_y);
    int gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = draw_pause(send_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sq_y, sq_x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random stalls before each transfer
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
      stall = draw_pause(recv_steady);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [15:0] sx, sy;
    int          pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // corners and extremes
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    // origin
    send_sample(16'h8000, 16'h8000);
    // one sample inside each sector
    send_sample(16'hF000, 16'h8000);
    send_sample(16'h8000, 16'hF000);
    send_sample(16'h1000, 16'h8000);
    send_sample(16'h8000, 16'h1000);
    // ties on both diagonals
    send_sample(16'h1234, 16'h1234);
    send_sample(16'hC000, 16'hC000);
    send_sample(16'h4000, 16'hC000);
    send_sample(16'hC000, 16'h4000);
    send_sample(16'h0001, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0001);
    // one step away from the origin
    send_sample(16'h8001, 16'h8000);
    send_sample(16'h8000, 16'h8001);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8001, 16'h7FFF);
    in_tvalid <= 1'b0;
    drain_results();

    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 9);
      sx   = 16'($urandom_range(0, 16'hFFFF));
      sy   = 16'($urandom_range(0, 16'hFFFF));
      case (pick)
        0: sy = sx;                                   // diagonal tie
        1: begin                                      // anti-diagonal tie
          if (sx == 16'h0000) sx = 16'h0001;
          sy = 16'h0000 - sx;
        end
        2: begin                                      // close to the center
          sx = 16'(32'h8000 + $urandom_range(0, 15) - 32'd8);
          sy = 16'(32'h8000 + $urandom_range(0, 15) - 32'd8);
        end
        3: begin                                      // on the square border
          case ($urandom_range(0, 3))
            0: sx = 16'h0000;
            1: sx = 16'hFFFF;
            2: sy = 16'h0000;
            default: sy = 16'hFFFF;
          endcase
        end
        default: ;
      endcase
      send_sample(sx, sy);
      if (n == N_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        drain_results();
      end
    end
    in_tvalid <= 1'b0;
    drain_results();
    repeat (60) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/csd_pkg.sv
src/csd_div_cell.sv
src/csd_horner_cell.sv
src/concentric_square_to_disk.sv
src/csd_checker.sv
dv/csd_checker.sv
dv/tb_top.sv
